>>> rtl/maf_pkg.sv
// Moving average filter: shared types and constants.
// Register indexes, sequencer states and fixed field widths.
// No dependencies.
package maf_pkg;

    // window_size register width, fixed by the register map
    localparam int WIN_W = 7;
    // configuration index width (three registers)
    localparam int IDX_W = 2;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_WINDOW     = 2'd0;
    localparam reg_idx_t REG_INIT       = 2'd1;
    localparam reg_idx_t REG_SEED_FIRST = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd8;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> rtl/moving_average_filter.sv
// A sample is accepted only in idle and passes the multiply, sum, divide and output
// states; the next is accepted once its average is presented, which out_stall can hold.
// The bit-serial divider by the window size makes one quotient bit per cycle.
// Reset: window 8, seed 0, seed-from-first off, sum/position cleared; the
// sample RAM is not cleared (entries are never read before being written).
// Depends on maf_pkg.
module moving_average_filter
    import maf_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write,
    input  reg_idx_t                       cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
    // sample channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    // average channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] average
);

    // ring address width
    localparam int POS_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    // exact sum: |sum| <= 2^(SAMPLE_WIDTH-1) * 127
    localparam int SUM_W  = SAMPLE_WIDTH + WIN_W;
    localparam int PROD_W = SAMPLE_WIDTH + WIN_W + 1;
    localparam int CNT_W  = $clog2(SUM_W);

    // ------------------------------------------------------------------
    // Sample RAM, one write and one registered read port
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];

    // ------------------------------------------------------------------
    // Control registers (reset)
    // ------------------------------------------------------------------
    state_t                         state_reg, state_next;
    logic [WIN_W-1:0]               window_reg, window_next;
    logic signed [SAMPLE_WIDTH-1:0] init_reg, init_next;
    logic                           sff_reg, sff_next;
    logic signed [SAMPLE_WIDTH-1:0] seed_reg, seed_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic                           wrapped_reg, wrapped_next;
    logic                           seen_first_reg, seen_first_next;
    logic                           base_pending_reg, base_pending_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic                           out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]               div_cnt_reg, div_cnt_next;

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic [POS_W-1:0]               cur_pos_reg, cur_pos_next;
    logic                           cur_wrap_reg, cur_wrap_next;
    logic signed [SUM_W-1:0]        base_reg, base_next;
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic [SUM_W-1:0]               quo_reg, quo_next;
    logic [WIN_W-1:0]               rem_reg, rem_next;
    logic                           neg_reg, neg_next;
    logic signed [SAMPLE_WIDTH-1:0] average_reg, average_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]               eff_n;
    logic                           in_acc;
    logic                           pos_over;
    logic [POS_W-1:0]               pos_use;
    logic                           wrap_use;
    logic                           mem_we;
    logic signed [PROD_W-1:0]       prod;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic signed [SUM_W-1:0]        sum_base;
    logic signed [SUM_W-1:0]        sum_new;
    logic [31:0]                    pos_inc;
    logic [WIN_W:0]                 rem_shift;
    logic                           rem_ge;
    logic [SUM_W-1:0]               quo_signed;
    logic                           cfg_hit;

    // Window clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (window_reg == '0)
        begin
            eff_n = WIN_W'(1);
        end
        else if (32'(window_reg) > 32'(WINDOW_MAX))
        begin
            eff_n = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_n = window_reg;
        end
    end

    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    // Stale position after a smaller window folds back to the start
    assign pos_over = (32'(pos_reg) >= 32'(eff_n));
    assign pos_use  = pos_over ? '0 : pos_reg;
    assign wrap_use = wrapped_reg || pos_over;

    assign mem_we = (state_reg == ST_SUM);

    // seed times window, for a restart or a seed taken from the first sample
    assign prod = PROD_W'(seed_reg) * $signed({1'b0, eff_n});

    // Until the ring has wrapped, the slot being replaced holds the seed
    assign old_sample = cur_wrap_reg ? rd_data_reg : seed_reg;
    assign sum_base   = base_pending_reg ? base_reg : sum_reg;
    assign sum_new    = sum_base - SUM_W'(old_sample) + SUM_W'(sample_reg);
    assign pos_inc    = 32'(cur_pos_reg) + 32'd1;

    // Restoring division step, one quotient bit per cycle
    assign rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge     = (rem_shift >= {1'b0, eff_n});
    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    assign cfg_hit = cfg_write &&
                     (cfg_index inside {REG_WINDOW, REG_INIT, REG_SEED_FIRST});

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        window_next       = window_reg;
        init_next         = init_reg;
        sff_next          = sff_reg;
        seed_next         = seed_reg;
        pos_next          = pos_reg;
        wrapped_next      = wrapped_reg;
        seen_first_next   = seen_first_reg;
        base_pending_next = base_pending_reg;
        sum_next          = sum_reg;
        out_valid_next    = out_valid_reg && out_stall;
        div_cnt_next      = div_cnt_reg;
        sample_next       = sample_reg;
        cur_pos_next      = cur_pos_reg;
        cur_wrap_next     = cur_wrap_reg;
        base_next         = base_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        average_next      = average_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sample_next     = sample;
                    cur_pos_next    = pos_use;
                    cur_wrap_next   = wrap_use;
                    seen_first_next = 1'b1;
                    if (sff_reg && !seen_first_reg)
                    begin
                        seed_next         = sample;
                        base_pending_next = 1'b1;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // RAM read data lands this cycle
                base_next  = prod[SUM_W-1:0];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next          = sum_new;
                base_pending_next = 1'b0;
                if (pos_inc >= 32'(eff_n))
                begin
                    pos_next     = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    pos_next     = pos_inc[POS_W-1:0];
                    wrapped_next = cur_wrap_reg;
                end
                neg_next     = sum_new[SUM_W-1];
                quo_next     = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;
                rem_next     = '0;
                div_cnt_next = CNT_W'(SUM_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[SUM_W-2:0], rem_ge};
                rem_next = rem_ge ? WIN_W'(rem_shift - {1'b0, eff_n})
                                  : rem_shift[WIN_W-1:0];
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    average_next   = quo_signed[SAMPLE_WIDTH-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any register write restarts the filter (the user must write only while idle; the block does not enforce it)
        if (cfg_hit)
        begin
            case (cfg_index)
                REG_WINDOW:     window_next = cfg_data[WIN_W-1:0];
                REG_INIT:       init_next   = cfg_data;
                REG_SEED_FIRST: sff_next    = cfg_data[0];
                default:        ;
            endcase
            seed_next         = (cfg_index == REG_INIT) ? cfg_data : init_reg;
            pos_next          = '0;
            wrapped_next      = 1'b0;
            seen_first_next   = 1'b0;
            base_pending_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_reg       <= WINDOW_RESET;
            init_reg         <= '0;
            sff_reg          <= 1'b0;
            seed_reg         <= '0;
            pos_reg          <= '0;
            wrapped_reg      <= 1'b0;
            seen_first_reg   <= 1'b0;
            base_pending_reg <= 1'b1;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            window_reg       <= window_next;
            init_reg         <= init_next;
            sff_reg          <= sff_next;
            seed_reg         <= seed_next;
            pos_reg          <= pos_next;
            wrapped_reg      <= wrapped_next;
            seen_first_reg   <= seen_first_next;
            base_pending_reg <= base_pending_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= out_valid_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        cur_pos_reg  <= cur_pos_next;
        cur_wrap_reg <= cur_wrap_next;
        base_reg     <= base_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        average_reg  <= average_next;
    end

    // Sample RAM: write-back of the new sample, registered read at accept
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_pos_reg] <= sample_reg;
        end
        if (in_acc)
        begin
            rd_data_reg <= mem[pos_use];
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("average presented without a finished division");

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (32'(cur_pos_reg) < 32'(eff_n)))
        else $error("ring position outside the window");

    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (quo_reg[SUM_W-1:SAMPLE_WIDTH] == '0))
        else $error("quotient exceeds the sample range");

    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (rem_reg < eff_n))
        else $error("division remainder not below window");

    a_base_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUM) && !cfg_hit) |=> !base_pending_reg)
        else $error("seeded sum not consumed");

endmodule
